>>> hdl/anc_cpp_pkg.sv
// ----------------------------------------------------------------------------
// anc_cpp_pkg
// Shared constants and types for the ANC caption packet parser.
// ----------------------------------------------------------------------------
package anc_cpp_pkg;

  localparam int CNT_W = 5;  // triplet count / cc_count width

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_NO_FLAG   = 4'd2;
  localparam logic [3:0] ST_COUNT     = 4'd3;
  localparam logic [3:0] ST_PARITY    = 4'd4;
  localparam logic [3:0] ST_ANC_SUM   = 4'd5;
  localparam logic [3:0] ST_NOT_708   = 4'd6;
  localparam logic [3:0] ST_CDP_HDR   = 4'd7;
  localparam logic [3:0] ST_CDP_LEN   = 4'd8;
  localparam logic [3:0] ST_CDP_SUM   = 4'd9;
  localparam logic [3:0] ST_RATE      = 4'd10;
  localparam logic [3:0] ST_FLAGS     = 4'd11;
  localparam logic [3:0] ST_CCDATA_ID = 4'd12;
  localparam logic [3:0] ST_CC_COUNT  = 4'd13;
  localparam logic [3:0] ST_FOOTER_ID = 4'd14;
  localparam logic [3:0] ST_SEQ       = 4'd15;

  localparam logic [7:0] ANC_DID     = 8'h61;
  localparam logic [7:0] ANC_SDID    = 8'h01;
  localparam logic [7:0] CDP_ID0     = 8'h96;
  localparam logic [7:0] CDP_ID1     = 8'h69;
  localparam logic [7:0] CCDATA_ID   = 8'h72;
  localparam logic [7:0] FOOTER_ID   = 8'h74;
  localparam logic [7:0] FLAGS_MASK  = 8'h43;
  localparam logic [7:0] CC_MIN_LEN  = 8'd13;
  localparam logic [9:0] ANC_ONES    = 10'h3ff;

  // finished line handed from parser to output side
  typedef struct packed {
    logic [3:0]       status;
    logic [CNT_W-1:0] count;
    logic             bank;
  } anc_job_t;

endpackage

>>> hdl/anc_cpp_if.sv
// ----------------------------------------------------------------------------
// anc_cpp_if
// Valid/ready channels for line words and parser results.
// ----------------------------------------------------------------------------
interface anc_word_if;
  logic       valid;
  logic       ready;
  logic [9:0] word;
  logic       last;

  modport source (output valid, word, last, input ready);
  modport sink (input valid, word, last, output ready);
endinterface

interface anc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       has_triplet;
  logic [7:0] cc_marker_type;
  logic [7:0] cc_byte_one;
  logic [7:0] cc_byte_two;
  logic       final_result;

  modport source (output valid, status, has_triplet, cc_marker_type, cc_byte_one,
                  cc_byte_two, final_result, input ready);
  modport sink (input valid, status, has_triplet, cc_marker_type, cc_byte_one,
                cc_byte_two, final_result, output ready);
endinterface

>>> hdl/anc_caption_packet_parser.sv
// ----------------------------------------------------------------------------
// anc_caption_packet_parser
// Parses one ANC line carrying a CEA-708 caption packet and returns a status
// word or the caption triplets of the line.
// ----------------------------------------------------------------------------
//  channel     dir  payload                                      accepted when
//  line_words  in   word[9:0], last                              valid && ready
//  results     out  status, has_triplet, cc_marker_type,         valid && ready
//                   cc_byte_one, cc_byte_two, final_result
//
// One line word per cycle. Triplets go to a two-bank memory, the bank
// alternating per line; a finished line waits in a one-job slot until the
// output side takes it. Status-only lines leave at one word per cycle;
// a triplet is read from memory, then registered out, before the next read.
// Input stalls only while a finished line waits behind one still playing out,
// or the output is stalled. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module anc_caption_packet_parser import anc_cpp_pkg::*; #(
  parameter int CC_SLOTS = 31
) (
  input  logic          clk,
  input  logic          rst,
  anc_word_if.sink      line_words,
  anc_result_if.source  results
);

  localparam int SLOT_W = (CC_SLOTS > 1) ? $clog2(CC_SLOTS) : 1;

  logic            job_room;
  logic            job_push;
  anc_job_t        job;
  logic            wr_en;
  logic [SLOT_W:0] wr_addr;
  logic [23:0]     wr_data;
  logic            rd_en;
  logic [SLOT_W:0] rd_addr;
  logic [23:0]     rd_data;

  anc_cpp_parse #(
    .CC_SLOTS (CC_SLOTS),
    .SLOT_W   (SLOT_W)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .line_words (line_words),
    .job_room   (job_room),
    .job_push   (job_push),
    .job        (job),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  anc_cpp_store #(
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  anc_cpp_emit #(
    .SLOT_W (SLOT_W)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_push (job_push),
    .job      (job),
    .job_room (job_room),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .results  (results)
  );

endmodule

>>> hdl/anc_cpp_store.sv
// ----------------------------------------------------------------------------
// anc_cpp_store
// Two-bank triplet memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module anc_cpp_store #(
  parameter int SLOT_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W:0]   wr_addr,
  input  logic [23:0]       wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W:0]   rd_addr,
  output logic [23:0]       rd_data
);

  logic [23:0] mem [0:(2**(SLOT_W+1))-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/anc_cpp_parse.sv
// ----------------------------------------------------------------------------
// anc_cpp_parse
// Per-word ANC / CDP checks; stores caption triplets and posts a line job.
// ----------------------------------------------------------------------------
module anc_cpp_parse import anc_cpp_pkg::*; #(
  parameter int CC_SLOTS = 31,
  parameter int SLOT_W   = 5
) (
  input  logic             clk,
  input  logic             rst,
  anc_word_if.sink         line_words,
  input  logic             job_room,
  output logic             job_push,
  output anc_job_t         job,
  output logic             wr_en,
  output logic [SLOT_W:0]  wr_addr,
  output logic [23:0]      wr_data
);

  logic [8:0]       pos, pos_next;
  logic [7:0]       dcount, dcount_next;
  logic [8:0]       anc_sum, anc_sum_next;
  logic [7:0]       cdp_sum, cdp_sum_next;
  logic [15:1]      fail, fail_next;
  logic [15:0]      seq_hdr, seq_hdr_next;
  logic [7:0]       foot_hi, foot_hi_next;
  logic [CNT_W-1:0] tcount, tcount_next;
  logic [15:0]      partial, partial_next;
  logic [CNT_W-1:0] cc_want, cc_want_next;
  logic [1:0]       phase, phase_next;
  logic             bank;

  logic             accept;
  logic [9:0]       w;
  logic [7:0]       b;
  logic [7:0]       c;
  logic [6:0]       three_want;
  logic [6:0]       three_cc;
  logic [9:0]       expect_sum;
  logic [3:0]       status;

  assign line_words.ready = job_room;
  assign accept = line_words.valid && line_words.ready;
  assign w = line_words.word;
  assign b = w[7:0];
  assign c = 8'(pos - 9'd6);
  assign three_want = {1'b0, cc_want, 1'b0} + 7'(cc_want);
  assign three_cc = {1'b0, b[4:0], 1'b0} + 7'(b[4:0]);
  assign expect_sum = {~anc_sum[8], anc_sum};

  always_comb begin
    pos_next     = pos;
    dcount_next  = dcount;
    anc_sum_next = anc_sum;
    cdp_sum_next = cdp_sum;
    fail_next    = fail;
    seq_hdr_next = seq_hdr;
    foot_hi_next = foot_hi;
    tcount_next  = tcount;
    partial_next = partial;
    cc_want_next = cc_want;
    phase_next   = phase;
    wr_en        = 1'b0;
    wr_addr      = {bank, tcount[SLOT_W-1:0]};
    wr_data      = {partial, b};

    if (pos < 9'd3) begin
      if (w != ((pos == 9'd0) ? 10'd0 : ANC_ONES)) fail_next[ST_NO_FLAG] = 1'b1;
    end else if (pos > 9'd5 && {1'b0, pos} >= 10'(dcount) + 10'd7) begin
      // past the packet: ignored
    end else if (pos <= 9'd5 || {1'b0, pos} <= 10'(dcount) + 10'd5) begin
      if ((^b) != w[8] || w[9] == w[8]) fail_next[ST_PARITY] = 1'b1;
      anc_sum_next = anc_sum + w[8:0];
      if (pos == 9'd3 && b != ANC_DID) fail_next[ST_NOT_708] = 1'b1;
      if (pos == 9'd4 && b != ANC_SDID) fail_next[ST_NOT_708] = 1'b1;
      if (pos == 9'd5) begin
        dcount_next = b;
        if (b < 8'd2) fail_next[ST_CDP_HDR] = 1'b1;
        if (b < CC_MIN_LEN) fail_next[ST_CDP_LEN] = 1'b1;
      end
      if (pos >= 9'd6) begin
        if (c == 8'd0 && b != CDP_ID0) fail_next[ST_CDP_HDR] = 1'b1;
        if (c == 8'd1 && b != CDP_ID1) fail_next[ST_CDP_HDR] = 1'b1;
        if (dcount >= CC_MIN_LEN) begin
          if (c == dcount - 8'd1) begin
            if (cdp_sum + b != 8'd0) fail_next[ST_CDP_SUM] = 1'b1;
          end else begin
            cdp_sum_next = cdp_sum + b;
          end
          if (c == 8'd2 && b != dcount) fail_next[ST_CDP_LEN] = 1'b1;
          if (c == 8'd3 && (b[3:0] == 4'd0 || b[7:4] > 4'd8)) fail_next[ST_RATE] = 1'b1;
          if (c == 8'd4 && (b & FLAGS_MASK) == 8'd0) fail_next[ST_FLAGS] = 1'b1;
          if (c == 8'd5) seq_hdr_next = {b, 8'd0};
          if (c == 8'd6) seq_hdr_next = {seq_hdr[15:8], b};
          if (c == 8'd7 && b != CCDATA_ID) fail_next[ST_CCDATA_ID] = 1'b1;
          if (c == 8'd8) begin
            if (b[7:5] == 3'd0) fail_next[ST_CC_COUNT] = 1'b1;
            if (8'(dcount - CC_MIN_LEN) < 8'(three_cc)) fail_next[ST_CC_COUNT] = 1'b1;
            if (b[4:0] > CNT_W'(CC_SLOTS)) fail_next[ST_CC_COUNT] = 1'b1;
            cc_want_next = b[4:0];
            phase_next   = 2'd0;
          end
          if (c >= 8'd9 && {1'b0, c} < 9'd9 + 9'(three_want)) begin
            case (phase)
              2'd0: begin
                partial_next = {b, 8'd0};
                phase_next   = 2'd1;
              end
              2'd1: begin
                partial_next = {partial[15:8], b};
                phase_next   = 2'd2;
              end
              default: begin
                phase_next = 2'd0;
                if (tcount < CNT_W'(CC_SLOTS)) begin
                  wr_en       = accept;
                  tcount_next = tcount + 1'b1;
                end
              end
            endcase
          end
          if (c == dcount - 8'd4 && b != FOOTER_ID) fail_next[ST_FOOTER_ID] = 1'b1;
          if (c == dcount - 8'd3) foot_hi_next = b;
          if (c == dcount - 8'd2 && {foot_hi, b} != seq_hdr) fail_next[ST_SEQ] = 1'b1;
        end
      end
    end else begin
      if (w != expect_sum) fail_next[ST_ANC_SUM] = 1'b1;
    end
  end

  // line status from the updated check flags
  always_comb begin
    status = ST_OK;
    if (pos < 9'd2) begin
      status = ST_SHORT;
    end else if (fail_next[ST_NO_FLAG]) begin
      status = ST_NO_FLAG;
    end else if (pos < 9'd5 || 10'(dcount_next) + 10'd7 > 10'(pos) + 10'd1) begin
      status = ST_COUNT;
    end else begin
      for (int n = 15; n >= 4; n--) begin
        if (fail_next[n]) status = 4'(n);
      end
    end
  end

  assign job_push   = accept && line_words.last;
  assign job.status = status;
  assign job.count  = tcount_next;
  assign job.bank   = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      dcount  <= '0;
      anc_sum <= '0;
      cdp_sum <= '0;
      fail    <= '0;
      seq_hdr <= '0;
      foot_hi <= '0;
      tcount  <= '0;
      partial <= '0;
      cc_want <= '0;
      phase   <= '0;
      bank    <= 1'b0;
    end else if (accept) begin
      if (line_words.last) begin
        pos     <= '0;
        dcount  <= '0;
        anc_sum <= '0;
        cdp_sum <= '0;
        fail    <= '0;
        seq_hdr <= '0;
        foot_hi <= '0;
        tcount  <= '0;
        partial <= '0;
        cc_want <= '0;
        phase   <= '0;
        bank    <= ~bank;
      end else begin
        pos     <= (pos == 9'd511) ? pos : pos + 9'd1;
        dcount  <= dcount_next;
        anc_sum <= anc_sum_next;
        cdp_sum <= cdp_sum_next;
        fail    <= fail_next;
        seq_hdr <= seq_hdr_next;
        foot_hi <= foot_hi_next;
        tcount  <= tcount_next;
        partial <= partial_next;
        cc_want <= cc_want_next;
        phase   <= phase_next;
      end
    end
  end

endmodule

>>> hdl/anc_cpp_emit.sv
// ----------------------------------------------------------------------------
// anc_cpp_emit
// Holds one pending line job and plays it out: a status word, or the stored
// triplets read back from the triplet memory.
// ----------------------------------------------------------------------------
module anc_cpp_emit import anc_cpp_pkg::*; #(
  parameter int SLOT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_push,
  input  anc_job_t         job,
  output logic             job_room,
  output logic             rd_en,
  output logic [SLOT_W:0]  rd_addr,
  input  logic [23:0]      rd_data,
  anc_result_if.source     results
);

  logic             pend_valid;
  anc_job_t         pend;
  logic             busy;
  logic             rd_pend;
  logic             rd_last;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic             cur_bank;

  logic out_free;
  logic pend_triplets;
  logic take;
  logic issue;

  assign out_free      = !results.valid || results.ready;
  assign pend_triplets = (pend.status == ST_OK) && (pend.count != '0);
  // busy covers the read still in flight
  assign take     = pend_valid && !busy && (pend_triplets || out_free);
  assign job_room = !pend_valid || take;
  assign issue    = busy && !rd_pend && !rd_last && out_free;
  assign rd_en    = issue;
  assign rd_addr  = {cur_bank, idx[SLOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      busy          <= 1'b0;
      rd_pend       <= 1'b0;
      rd_last       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (job_push) begin
        pend_valid <= 1'b1;
        pend       <= job;
      end else if (take) begin
        pend_valid <= 1'b0;
      end

      if (results.valid && results.ready) results.valid <= 1'b0;

      if (take) begin
        if (pend_triplets) begin
          busy     <= 1'b1;
          idx      <= '0;
          cnt      <= pend.count;
          cur_bank <= pend.bank;
          rd_last  <= 1'b0;
        end else begin
          results.valid          <= 1'b1;
          results.status         <= pend.status;
          results.has_triplet    <= 1'b0;
          results.cc_marker_type <= 8'd0;
          results.cc_byte_one    <= 8'd0;
          results.cc_byte_two    <= 8'd0;
          results.final_result   <= 1'b1;
        end
      end

      if (issue) begin
        rd_pend <= 1'b1;
        idx     <= idx + 1'b1;
        rd_last <= (idx + 1'b1 == cnt);
      end

      // read data lands in the cycle after issue; the output slot was freed then
      if (rd_pend) begin
        rd_pend                <= 1'b0;
        results.valid          <= 1'b1;
        results.status         <= ST_OK;
        results.has_triplet    <= 1'b1;
        results.cc_marker_type <= rd_data[23:16];
        results.cc_byte_one    <= rd_data[15:8];
        results.cc_byte_two    <= rd_data[7:0];
        results.final_result   <= rd_last;
        if (rd_last) begin
          busy    <= 1'b0;
          rd_last <= 1'b0;
        end
      end
    end
  end

endmodule

>>> tb/anc_caption_packet_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anc_caption_packet_parser_tb
// Feeds ANC lines (clean caption packets, packets with one broken field, and
// noise) through the parser, predicts the status or triplet results of each
// line and checks every result word against the prediction.
// ----------------------------------------------------------------------------
module anc_caption_packet_parser_tb;
  import anc_cpp_pkg::*;

  localparam int CC_SLOTS    = 31;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;

  typedef enum int {
    FLT_NONE, FLT_FLAG, FLT_DID, FLT_SDID, FLT_PARITY, FLT_ANC_SUM, FLT_TRUNC,
    FLT_SHORT_DC, FLT_HDR, FLT_LEN, FLT_CDP_SUM, FLT_RATE, FLT_FLAGS, FLT_CCDATA,
    FLT_CC_MARK, FLT_CC_BIG, FLT_FOOTER, FLT_SEQ
  } line_fault_e;

  typedef enum logic [1:0] {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [9:0] word;
    logic       last;
    logic       hold;
    idle_mode_e mode;
  } line_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic       has_triplet;
    logic [7:0] marker_type;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic       final_result;
  } caption_result_t;

  logic clk;
  logic rst;

  anc_word_if   line_if ();
  anc_result_if res_if ();

  anc_caption_packet_parser #(.CC_SLOTS(CC_SLOTS)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .line_words (line_if),
    .results    (res_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  line_item_t      line_words_q [$];
  caption_result_t expected_captions [$];
  idle_mode_e      cur_mode;
  int              line_no;
  int              mismatch_count;
  int              cycle_count;

  // line parser state
  logic [8:0]  pos_q;
  logic [7:0]  dcount;
  logic [8:0]  anc_sum;
  logic [7:0]  cdp_sum;
  logic [15:1] fails;   // bit n set when check n failed
  logic [15:0] seq_hdr;
  logic [15:0] seq_ftr;
  logic [5:0]  trip_cnt;
  logic [15:0] partial;
  logic [4:0]  cc_want;
  logic [23:0] trip_mem [CC_SLOTS];

  function automatic void clear_line_state();
    pos_q    = '0;
    dcount   = '0;
    anc_sum  = '0;
    cdp_sum  = '0;
    fails    = '0;
    seq_hdr  = '0;
    seq_ftr  = '0;
    trip_cnt = '0;
    partial  = '0;
    cc_want  = '0;
  endfunction

  function automatic void parse_cdp_byte(input int c, input logic [7:0] b);
    int len;
    int cc;
    logic [7:0] s8;
    len = dcount;
    if (c == 0 && b != CDP_ID0) fails[ST_CDP_HDR] = 1'b1;
    if (c == 1 && b != CDP_ID1) fails[ST_CDP_HDR] = 1'b1;
    if (len < CC_MIN_LEN) return;

    if (c == len - 1) begin
      s8 = cdp_sum + b;
      if (s8 != 8'h00) fails[ST_CDP_SUM] = 1'b1;
    end else begin
      cdp_sum = cdp_sum + b;
    end

    if (c == 2 && int'(b) != len) fails[ST_CDP_LEN] = 1'b1;
    if (c == 3 && (b[3:0] == 4'h0 || b[7:4] > 4'd8)) fails[ST_RATE] = 1'b1;
    if (c == 4 && (b & FLAGS_MASK) == 8'h00) fails[ST_FLAGS] = 1'b1;
    if (c == 5) seq_hdr = {b, 8'h00};
    if (c == 6) seq_hdr = seq_hdr | {8'h00, b};
    if (c == 7 && b != CCDATA_ID) fails[ST_CCDATA_ID] = 1'b1;
    if (c == 8) begin
      cc = b[4:0];
      if (b[7:5] == 3'b000) fails[ST_CC_COUNT] = 1'b1;
      if (len - 13 < 3 * cc) fails[ST_CC_COUNT] = 1'b1;
      if (cc > CC_SLOTS) fails[ST_CC_COUNT] = 1'b1;
      cc_want = cc[4:0];
    end
    if (c >= 9 && c < 9 + 3 * int'(cc_want)) begin
      case ((c - 9) % 3)
        0: partial = {b, 8'h00};
        1: partial = partial | {8'h00, b};
        default: begin
          if (trip_cnt < CC_SLOTS) begin
            trip_mem[trip_cnt] = {partial, b};
            trip_cnt = trip_cnt + 1'b1;
          end
        end
      endcase
    end
    if (c == len - 4 && b != FOOTER_ID) fails[ST_FOOTER_ID] = 1'b1;
    if (c == len - 3) seq_ftr = {b, 8'h00};
    if (c == len - 2) begin
      seq_ftr = seq_ftr | {8'h00, b};
      if (seq_ftr != seq_hdr) fails[ST_SEQ] = 1'b1;
    end
  endfunction

  function automatic void parse_anc_word(input int p, input logic [9:0] w);
    int dc;
    logic [7:0] b;
    dc = dcount;
    b  = w[7:0];
    if (p < 3) begin
      if (w != ((p == 0) ? 10'h000 : ANC_ONES)) fails[ST_NO_FLAG] = 1'b1;
      return;
    end
    if (p > 5 && p >= dc + 7) return;  // past the packet

    if (p <= 5 || p <= dc + 5) begin
      if ((^b) != w[8] || w[9] == w[8]) fails[ST_PARITY] = 1'b1;
      anc_sum = anc_sum + w[8:0];
      if (p == 3 && b != ANC_DID) fails[ST_NOT_708] = 1'b1;
      if (p == 4 && b != ANC_SDID) fails[ST_NOT_708] = 1'b1;
      if (p == 5) begin
        dcount = b;
        if (b < 8'd2) fails[ST_CDP_HDR] = 1'b1;
        if (b < CC_MIN_LEN) fails[ST_CDP_LEN] = 1'b1;
      end
      if (p >= 6) parse_cdp_byte(p - 6, b);
    end else begin
      if (w != {~anc_sum[8], anc_sum}) fails[ST_ANC_SUM] = 1'b1;
    end
  endfunction

  function automatic void predict_line_word(input logic [9:0] w, input logic lst);
    int p;
    int n_words;
    logic [3:0] st;
    caption_result_t r;
    p = pos_q;
    parse_anc_word(p, w);
    if (!lst) begin
      if (pos_q != 9'd511) pos_q = pos_q + 1'b1;
      return;
    end

    n_words = p + 1;
    st = ST_OK;
    if (n_words < 3) begin
      st = ST_SHORT;
    end else if (fails[ST_NO_FLAG]) begin
      st = ST_NO_FLAG;
    end else if (p < 5 || int'(dcount) + 7 > n_words) begin
      st = ST_COUNT;
    end else begin
      for (int k = ST_SEQ; k >= ST_PARITY; k--) begin
        if (fails[k]) st = 4'(k);
      end
    end

    if (st != ST_OK || trip_cnt == 0) begin
      r = '{status: st, has_triplet: 1'b0, marker_type: 8'h00, byte_one: 8'h00,
            byte_two: 8'h00, final_result: 1'b1};
      expected_captions.push_back(r);
    end else begin
      for (int k = 0; k < trip_cnt; k++) begin
        r = '{status: ST_OK, has_triplet: 1'b1, marker_type: trip_mem[k][23:16],
              byte_one: trip_mem[k][15:8], byte_two: trip_mem[k][7:0],
              final_result: (k == trip_cnt - 1)};
        expected_captions.push_back(r);
      end
    end
    clear_line_state();
  endfunction

  function automatic logic [9:0] anc_enc(input logic [7:0] b);
    return {~(^b), ^b, b};
  endfunction

  function automatic void push_line(ref logic [9:0] lw [$]);
    line_item_t it;
    for (int i = 0; i < lw.size(); i++) begin
      it.word = lw[i];
      it.last = (i == lw.size() - 1);
      it.hold = (line_no % 5 == 0) && (i == 0);
      it.mode = idle_mode_e'((line_no / 5) % 4);
      line_words_q.push_back(it);
    end
    line_no++;
  endfunction

  // Builds one line around a caption packet with cc triplets and extra filler
  // bytes, breaks the field named by fault, cuts it to keep words when keep is
  // nonzero (FLT_TRUNC picks a random keep) and appends pad ignored words. For
  // a short packet extra is the data count. Returns the word count before pad.
  function automatic int add_line(input int cc, input int extra, input line_fault_e fault,
                                  input int keep, input int pad);
    logic [7:0] cdp [$];
    logic [9:0] lw [$];
    logic [7:0] nz;
    logic [7:0] t8;
    logic [7:0] sum8;
    logic [8:0] sum9;
    logic [9:0] t10;
    int len;
    int n;
    int body;
    nz = 8'($urandom_range(1, 255));
    if (fault == FLT_SHORT_DC) begin
      len = extra;
      for (int i = 0; i < len; i++) cdp.push_back(8'($urandom));
      if (len >= 2 && $urandom_range(0, 1)) begin
        cdp[0] = CDP_ID0;
        cdp[1] = CDP_ID1;
      end
    end else begin
      len = 13 + 3 * cc + extra;
      cdp.push_back(CDP_ID0);
      cdp.push_back(CDP_ID1);
      cdp.push_back(8'(len));
      cdp.push_back({4'($urandom_range(0, 8)), 4'($urandom_range(1, 15))});
      t8 = 8'($urandom);
      if ((t8 & FLAGS_MASK) == 8'h00) t8 = t8 | 8'h01;
      cdp.push_back(t8);
      cdp.push_back(8'($urandom));
      cdp.push_back(8'($urandom));
      cdp.push_back(CCDATA_ID);
      cdp.push_back({3'($urandom_range(1, 7)), 5'(cc)});
      for (int i = 0; i < 3 * cc + extra; i++) cdp.push_back(8'($urandom));
      cdp.push_back(FOOTER_ID);
      cdp.push_back(cdp[5]);
      cdp.push_back(cdp[6]);

      case (fault)
        FLT_HDR: begin
          n = $urandom_range(0, 1);
          cdp[n] = cdp[n] ^ nz;
        end
        FLT_LEN:    cdp[2] = cdp[2] ^ nz;
        FLT_RATE: begin
          t8 = cdp[3];
          if ($urandom_range(0, 1)) cdp[3] = {t8[7:4], 4'h0};
          else cdp[3] = {4'($urandom_range(9, 15)), t8[3:0]};
        end
        FLT_FLAGS:   cdp[4] = cdp[4] & ~FLAGS_MASK;
        FLT_CCDATA:  cdp[7] = cdp[7] ^ nz;
        FLT_CC_MARK: cdp[8] = cdp[8] & 8'h1f;
        FLT_CC_BIG: begin
          t8 = cdp[8];
          if (cc + extra / 3 < CC_SLOTS)
            cdp[8] = {t8[7:5], 5'($urandom_range(cc + extra / 3 + 1, CC_SLOTS))};
        end
        FLT_FOOTER: cdp[len - 4] = cdp[len - 4] ^ nz;
        FLT_SEQ: begin
          n = len - 2 - $urandom_range(0, 1);
          cdp[n] = cdp[n] ^ nz;
        end
        default: ;
      endcase

      sum8 = '0;
      foreach (cdp[i]) sum8 = sum8 + cdp[i];
      cdp.push_back(8'h00 - sum8);
      if (fault == FLT_CDP_SUM) cdp[len - 1] = cdp[len - 1] ^ nz;
    end

    lw.push_back(10'h000);
    lw.push_back(ANC_ONES);
    lw.push_back(ANC_ONES);
    lw.push_back(anc_enc(ANC_DID));
    lw.push_back(anc_enc(ANC_SDID));
    lw.push_back(anc_enc(8'(len)));
    foreach (cdp[i]) lw.push_back(anc_enc(cdp[i]));
    sum9 = '0;
    for (int i = 3; i < lw.size(); i++) begin
      t10 = lw[i];
      sum9 = sum9 + t10[8:0];
    end
    lw.push_back({~sum9[8], sum9});

    case (fault)
      FLT_FLAG: begin
        n = $urandom_range(0, 2);
        lw[n] = lw[n] ^ 10'($urandom_range(1, 1023));
      end
      FLT_DID:  lw[3] = anc_enc(ANC_DID ^ nz);
      FLT_SDID: lw[4] = anc_enc(ANC_SDID ^ nz);
      FLT_PARITY: begin
        n = $urandom_range(3, lw.size() - 2);
        case ($urandom_range(0, 2))
          0: lw[n] = lw[n] ^ 10'h200;
          1: lw[n] = lw[n] ^ 10'h100;
          default: lw[n] = lw[n] ^ 10'h001;
        endcase
      end
      FLT_ANC_SUM: lw[lw.size() - 1] = lw[lw.size() - 1] ^ 10'($urandom_range(1, 1023));
      default: ;
    endcase

    n = lw.size();
    if (fault == FLT_TRUNC && keep == 0) keep = $urandom_range(3, n - 1);
    if (keep > 0 && keep < n) begin
      while (lw.size() > keep) void'(lw.pop_back());
    end
    body = lw.size();
    for (int i = 0; i < pad; i++) lw.push_back(10'($urandom));
    push_line(lw);
    return body;
  endfunction

  function automatic int add_noise_line(input int n);
    logic [9:0] lw [$];
    logic [9:0] w;
    for (int i = 0; i < n; i++) begin
      w = 10'($urandom);
      if (i < 3 && $urandom_range(0, 1)) w = (i == 0) ? 10'h000 : ANC_ONES;
      lw.push_back(w);
    end
    push_line(lw);
    return n;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // word driver; predicts on every accepted word
  always @(posedge clk) begin : word_driver
    line_item_t it;
    logic send;
    if (rst) begin
      line_if.valid <= 1'b0;
    end else begin
      if (line_if.valid && line_if.ready) predict_line_word(line_if.word, line_if.last);
      if (!line_if.valid || line_if.ready) begin
        send = 1'b0;
        if (line_words_q.size() > 0) begin
          it = line_words_q[0];
          send = 1'b1;
          if (it.hold && expected_captions.size() > 0) send = 1'b0;
          if ((it.mode == IDLE_SENDER && $urandom_range(0, 99) < 47) ||
              (it.mode == IDLE_BOTH && $urandom_range(0, 99) < 17)) send = 1'b0;
        end
        if (send) begin
          void'(line_words_q.pop_front());
          cur_mode      <= it.mode;
          line_if.word  <= it.word;
          line_if.last  <= it.last;
          line_if.valid <= 1'b1;
        end else begin
          line_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    caption_result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_captions.size() == 0) begin
          $error("result word with nothing pending: status %0d triplet %0d",
                 res_if.status, res_if.has_triplet);
          mismatch_count++;
        end else begin
          want = expected_captions.pop_front();
          check_field("status", want.status, res_if.status);
          check_field("has_triplet", want.has_triplet, res_if.has_triplet);
          check_field("cc_marker_type", want.marker_type, res_if.cc_marker_type);
          check_field("cc_byte_one", want.byte_one, res_if.cc_byte_one);
          check_field("cc_byte_two", want.byte_two, res_if.cc_byte_two);
          check_field("final_result", want.final_result, res_if.final_result);
        end
      end
      if ((cur_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 47) ||
          (cur_mode == IDLE_BOTH && $urandom_range(0, 99) < 17))
        res_if.ready <= 1'b0;
      else
        res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_words;
    int est_results;
    int cc;
    int extra;
    int pad;
    int r;
    line_fault_e fault;
    rst            = 1'b1;
    line_if.valid  = 1'b0;
    line_if.word   = '0;
    line_if.last   = 1'b0;
    res_if.ready   = 1'b0;
    cur_mode       = IDLE_NONE;
    line_no        = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    rand_words     = 0;
    est_results    = 0;
    clear_line_state();
    foreach (trip_mem[i]) trip_mem[i] = '0;

    // directed lines
    void'(add_noise_line(1));
    void'(add_noise_line(2));
    void'(add_line(0, 0, FLT_NONE, 0, 0));          // empty packet, shortest length
    void'(add_line(1, 0, FLT_NONE, 0, 2));
    void'(add_line(CC_SLOTS, 3, FLT_NONE, 0, 0));   // every triplet slot used
    void'(add_line(2, 1, FLT_FLAG, 0, 0));
    void'(add_line(2, 0, FLT_TRUNC, 3, 0));         // flag words only
    void'(add_line(2, 0, FLT_TRUNC, 5, 0));         // data count word missing
    void'(add_line(2, 2, FLT_TRUNC, 20, 0));        // packet longer than line
    void'(add_line(1, 0, FLT_PARITY, 0, 0));
    void'(add_line(1, 1, FLT_ANC_SUM, 0, 0));
    void'(add_line(0, 0, FLT_DID, 0, 0));
    void'(add_line(0, 0, FLT_SDID, 0, 0));
    void'(add_line(0, 0, FLT_SHORT_DC, 0, 0));
    void'(add_line(0, 1, FLT_SHORT_DC, 0, 0));
    void'(add_line(0, 12, FLT_SHORT_DC, 0, 0));
    void'(add_line(1, 0, FLT_HDR, 0, 0));
    void'(add_line(1, 0, FLT_LEN, 0, 0));
    void'(add_line(1, 0, FLT_CDP_SUM, 0, 0));
    void'(add_line(1, 0, FLT_RATE, 0, 0));
    void'(add_line(1, 0, FLT_FLAGS, 0, 0));
    void'(add_line(1, 0, FLT_CCDATA, 0, 0));
    void'(add_line(1, 0, FLT_CC_MARK, 0, 0));
    void'(add_line(2, 4, FLT_CC_BIG, 0, 0));
    void'(add_line(1, 0, FLT_FOOTER, 0, 0));
    void'(add_line(1, 0, FLT_SEQ, 0, 0));
    void'(add_line(3, 1, FLT_NONE, 0, 520));        // position counter saturates

    // random lines: mostly well formed, some with one broken field, some noise
    while (rand_words < 470 || est_results < 48) begin
      r     = $urandom_range(0, 99);
      cc    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, CC_SLOTS) : $urandom_range(0, 4);
      extra = $urandom_range(0, 3);
      pad   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (r >= 85) begin
        rand_words += add_noise_line($urandom_range(1, 12));
        est_results++;
      end else begin
        fault = FLT_NONE;
        if (r >= 55)
          fault = line_fault_e'($urandom_range(int'(FLT_FLAG), int'(FLT_SEQ)));
        if (fault == FLT_SHORT_DC) extra = $urandom_range(0, 12);
        rand_words += add_line(cc, extra, fault, 0, pad);
        est_results += (fault == FLT_NONE && cc > 0) ? cc : 1;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (line_words_q.size() > 0 || line_if.valid) @(posedge clk);
    while (expected_captions.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
